// ===== rtl/tl_pkg.sv =====
// Shared types, codes and character constants for the token lexer.
`default_nettype none
package tl_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_OP,
      MODE_NAME,
      MODE_NUM,
      MODE_DROP
   } mode_type;

   typedef enum logic [2:0] {
      KIND_OP     = 3'd0,
      KIND_PAREN  = 3'd1,
      KIND_LBRACE = 3'd2,
      KIND_RBRACE = 3'd3,
      KIND_SEMI   = 3'd4,
      KIND_NAME   = 3'd5,
      KIND_NUM    = 3'd6,
      KIND_END    = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      PART_WHOLE = 2'd0,
      PART_CHAR  = 2'd1,
      PART_CLOSE = 2'd2
   } part_type;

   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd2;
   localparam logic [3:0] OP_MUL    = 4'd4;
   localparam logic [3:0] OP_DIV    = 4'd5;
   localparam logic [3:0] OP_ASSIGN = 4'd6;
   localparam logic [3:0] OP_GT     = 4'd8;
   localparam logic [3:0] OP_LT     = 4'd10;
   localparam logic [3:0] OP_NOT    = 4'd12;
   localparam logic [3:0] OP_LPAREN = 4'd14;
   localparam logic [3:0] OP_RPAREN = 4'd15;
   localparam logic [3:0] OP_NONE   = 4'd0;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;

   localparam logic [30:0] NUM_MAX  = 31'h7FFF_FFFF;

   // result queue depth: must be a power of two, at least 2
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  op_code;
      part_type    part;
      logic [7:0]  name_char;
      logic [30:0] value;
      logic        last_of_run;
   } rsp_item_type;

   function automatic rsp_item_type make_item(kind_type k, logic [3:0] op, part_type p,
                                              logic [7:0] ch, logic [30:0] val);
      rsp_item_type r;
      r.kind        = k;
      r.op_code     = op;
      r.part        = p;
      r.name_char   = ch;
      r.value       = val;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return (b >= CH_LOW_A && b <= CH_LOW_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tl_req_if.sv =====
// Source byte channel: valid/ready handshake with one character per beat.
`default_nettype none
interface tl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       source_end;

   modport source (output valid, output byte_in, output source_end, input ready);
   modport sink (input valid, input byte_in, input source_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/tl_rsp_if.sv =====
// Token channel: valid/ready handshake with one token result per beat.
`default_nettype none
interface tl_rsp_if
   import tl_pkg::*;
;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [3:0]  op_code;
   part_type    part;
   logic [7:0]  name_char;
   logic [30:0] value;
   logic        last_of_run;

   modport source (output valid, output kind, output op_code, output part,
                   output name_char, output value, output last_of_run, input ready);
   modport sink (input valid, input kind, input op_code, input part,
                 input name_char, input value, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/token_lexer.sv =====
// Token lexer top level: input register, one-pass lexer step, result queue.
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    byte_in[7:0], source_end
//   rsp_bus   out  valid/ready    kind, op_code, part, name_char, value[30:0], last_of_run
//
// One source beat per cycle is taken while req_bus.ready is high; each beat gives
// zero, one or two token beats. A beat waits in the input register until the queue
// has room for two tokens, then the lexer step pushes its tokens into a 4-entry queue.
// Sustained output is one token per cycle while the sink is ready, so beats that give two
// tokens throttle the input once the queue fills. Reset (synchronous) empties everything.
`default_nettype none
module token_lexer
   import tl_pkg::*;
#(
   parameter int NAME_COUNT_MAX = 255
) (
   input  wire logic clock,
   input  wire logic reset,
   tl_req_if.sink    req_bus,
   tl_rsp_if.source  rsp_bus
);

   localparam int LEN_W = $clog2(NAME_COUNT_MAX + 1);

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_end_ff;
   logic        req_fire;
   logic        adv;
   logic        room_two;

   // lexer state
   mode_type    mode_ff, mode_in;
   logic [3:0]  pend_ff, pend_in;
   logic [30:0] acc_ff, acc_in;
   logic [LEN_W-1:0] len_ff, len_in;

   // step results
   rsp_item_type res [2];
   logic [1:0]   step_cnt;
   logic [1:0]   push_cnt;
   rsp_item_type fifo_out;

   // start-of-token decode
   logic         fi_has;
   rsp_item_type fi_item;
   mode_type     fi_mode;
   logic [3:0]   fi_pend;
   logic [30:0]  fi_acc;
   logic         fi_len_set;

   // pending-token flush
   logic         fl_has;
   rsp_item_type fl_item;

   logic [34:0]  acc_x10;
   logic [7:0]   digit;

   assign req_fire    = req_bus.valid && req_bus.ready;
   assign adv         = s1_valid_ff && room_two;
   assign req_bus.ready = !s1_valid_ff || room_two;
   assign s1_valid_in = req_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
   assign push_cnt    = adv ? step_cnt : 2'd0;
   assign digit       = s1_byte_ff - CH_ZERO;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_bus.byte_in;
         s1_end_ff  <= req_bus.source_end;
      end
   end

   // decode of a byte as the first byte of a new token
   always_comb begin
      fi_has     = 1'b0;
      fi_item    = make_item(KIND_END, OP_NONE, PART_WHOLE, 8'd0, 31'd0);
      fi_mode    = MODE_IDLE;
      fi_pend    = pend_ff;
      fi_acc     = acc_ff;
      fi_len_set = 1'b0;
      if (!is_space(s1_byte_ff)) begin
         case (s1_byte_ff)
            CH_PLUS: begin
               fi_pend = OP_ADD;
               fi_mode = MODE_OP;
            end
            CH_MINUS: begin
               fi_pend = OP_SUB;
               fi_mode = MODE_OP;
            end
            CH_EQUAL: begin
               fi_pend = OP_ASSIGN;
               fi_mode = MODE_OP;
            end
            CH_GT: begin
               fi_pend = OP_GT;
               fi_mode = MODE_OP;
            end
            CH_LT: begin
               fi_pend = OP_LT;
               fi_mode = MODE_OP;
            end
            CH_BANG: begin
               fi_pend = OP_NOT;
               fi_mode = MODE_OP;
            end
            CH_STAR: begin
               fi_has  = 1'b1;
               fi_item = make_item(KIND_OP, OP_MUL, PART_WHOLE, 8'd0, 31'd0);
            end
            CH_SLASH: begin
               fi_has  = 1'b1;
               fi_item = make_item(KIND_OP, OP_DIV, PART_WHOLE, 8'd0, 31'd0);
            end
            CH_LPAREN: begin
               fi_has  = 1'b1;
               fi_item = make_item(KIND_PAREN, OP_LPAREN, PART_WHOLE, 8'd0, 31'd0);
            end
            CH_RPAREN: begin
               fi_has  = 1'b1;
               fi_item = make_item(KIND_PAREN, OP_RPAREN, PART_WHOLE, 8'd0, 31'd0);
            end
            CH_LBRACE: begin
               fi_has  = 1'b1;
               fi_item = make_item(KIND_LBRACE, OP_NONE, PART_WHOLE, 8'd0, 31'd0);
            end
            CH_RBRACE: begin
               fi_has  = 1'b1;
               fi_item = make_item(KIND_RBRACE, OP_NONE, PART_WHOLE, 8'd0, 31'd0);
            end
            CH_SEMI: begin
               fi_has  = 1'b1;
               fi_item = make_item(KIND_SEMI, OP_NONE, PART_WHOLE, 8'd0, 31'd0);
            end
            default: begin
               if (is_alpha(s1_byte_ff)) begin
                  fi_has     = 1'b1;
                  fi_item    = make_item(KIND_NAME, OP_NONE, PART_CHAR, s1_byte_ff, 31'd0);
                  fi_mode    = MODE_NAME;
                  fi_len_set = 1'b1;
               end else if (is_digit(s1_byte_ff)) begin
                  fi_acc  = 31'(digit);
                  fi_mode = MODE_NUM;
               end else begin
                  // unknown byte: end token, then drop until end of source
                  fi_has  = 1'b1;
                  fi_mode = MODE_DROP;
               end
            end
         endcase
      end
   end

   // token held in state, emitted when something ends it
   always_comb begin
      fl_has  = 1'b0;
      fl_item = make_item(KIND_END, OP_NONE, PART_WHOLE, 8'd0, 31'd0);
      case (mode_ff)
         MODE_OP: begin
            fl_has  = 1'b1;
            fl_item = make_item(KIND_OP, pend_ff, PART_WHOLE, 8'd0, 31'd0);
         end
         MODE_NAME: begin
            fl_has  = 1'b1;
            fl_item = make_item(KIND_NAME, OP_NONE, PART_CLOSE, 8'd0, 31'(len_ff));
         end
         MODE_NUM: begin
            fl_has  = 1'b1;
            fl_item = make_item(KIND_NUM, OP_NONE, PART_WHOLE, 8'd0, acc_ff);
         end
         default: fl_has = 1'b0;
      endcase
   end

   assign acc_x10 = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + 35'(digit);

   // one lexer step on the registered beat
   always_comb begin
      res[0]   = make_item(KIND_END, OP_NONE, PART_WHOLE, 8'd0, 31'd0);
      res[1]   = res[0];
      step_cnt = 2'd0;
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      acc_in   = acc_ff;
      len_in   = len_ff;

      if (s1_end_ff) begin
         if (fl_has) begin
            res[0]   = fl_item;
            step_cnt = 2'd1;
         end
         res[step_cnt[0]] = make_item(KIND_END, OP_NONE, PART_WHOLE, 8'd0, 31'd0);
         step_cnt = step_cnt + 2'd1;
         mode_in  = MODE_IDLE;
      end else if (mode_ff == MODE_DROP) begin
         mode_in = MODE_DROP;
      end else if (mode_ff == MODE_OP && s1_byte_ff == CH_EQUAL) begin
         // two-character operator swallows the '='
         res[0]   = make_item(KIND_OP, pend_ff + 4'd1, PART_WHOLE, 8'd0, 31'd0);
         step_cnt = 2'd1;
         mode_in  = MODE_IDLE;
      end else if (mode_ff == MODE_NAME && (is_alpha(s1_byte_ff) || is_digit(s1_byte_ff))) begin
         res[0]   = make_item(KIND_NAME, OP_NONE, PART_CHAR, s1_byte_ff, 31'd0);
         step_cnt = 2'd1;
         if (len_ff < LEN_W'(NAME_COUNT_MAX)) begin
            len_in = len_ff + LEN_W'(1);
         end
      end else if (mode_ff == MODE_NUM && is_digit(s1_byte_ff)) begin
         acc_in = (acc_x10 > 35'(NUM_MAX)) ? NUM_MAX : acc_x10[30:0];
      end else begin
         if (fl_has) begin
            res[0]   = fl_item;
            step_cnt = 2'd1;
         end
         if (fi_has) begin
            res[step_cnt[0]] = fi_item;
            step_cnt = step_cnt + 2'd1;
         end
         mode_in = fi_mode;
         pend_in = fi_pend;
         acc_in  = fi_acc;
         if (fi_len_set) begin
            len_in = LEN_W'(1);
         end
      end

      res[0].last_of_run = step_cnt == 2'd1;
      res[1].last_of_run = step_cnt == 2'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= '0;
         acc_ff  <= '0;
         len_ff  <= '0;
      end else if (adv) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         acc_ff  <= acc_in;
         len_ff  <= len_in;
      end
   end

   tl_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_data (res),
      .room_two  (room_two),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (fifo_out)
   );

   assign rsp_bus.kind        = fifo_out.kind;
   assign rsp_bus.op_code     = fifo_out.op_code;
   assign rsp_bus.part        = fifo_out.part;
   assign rsp_bus.name_char   = fifo_out.name_char;
   assign rsp_bus.value       = fifo_out.value;
   assign rsp_bus.last_of_run = fifo_out.last_of_run;

`ifndef SYNTHESIS
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      adv && !s1_end_ff && mode_ff == MODE_DROP |-> push_cnt == 2'd0)
      else $error("token emitted while dropping bytes");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      adv && s1_end_ff |=> mode_ff == MODE_IDLE)
      else $error("lexer not idle after end of source");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      adv && s1_end_ff |-> step_cnt != 2'd0 && step_cnt != 2'd3)
      else $error("end of source gave no end token");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      adv && step_cnt == 2'd2 |-> !res[0].last_of_run && res[1].last_of_run)
      else $error("last_of_run misplaced in a two-token step");
`endif

endmodule
`default_nettype wire

// ===== rtl/tl_rsp_fifo.sv =====
// Result queue: takes up to two tokens per cycle, hands out one per cycle.
`default_nettype none
module tl_rsp_fifo
   import tl_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [1:0]   push_cnt,
   input  rsp_item_type      push_data [2],
   output logic              room_two,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_item_type      out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room_two  = count_ff <= CNT_W'(DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push_data[1];
      end
   end

endmodule
`default_nettype wire
